FILE: hw/rtl/psc_pkg.sv
// package for the pinned slot cache replacer
// holds beat structs, function codes, slot update commands and controller states
// no dependencies
package psc_pkg;

  // default sizing
  localparam int SLOTS_DEF      = 8;
  localparam int STAMP_BITS_DEF = 32;
  localparam int COUNT_BITS     = 32;
  localparam int LAYER_BITS     = 16;

  // function codes of an input beat
  localparam logic [2:0] FUNC_ACCESS      = 3'd0;
  localparam logic [2:0] FUNC_RELEASE     = 3'd1;
  localparam logic [2:0] FUNC_CLR_PERM    = 3'd2;
  localparam logic [2:0] FUNC_ACCESS_PERM = 3'd3;
  localparam logic [2:0] FUNC_CLR_CACHE   = 3'd4;

  // input beat
  typedef struct packed {
    logic [2:0]            func;
    logic [LAYER_BITS-1:0] layer_num;
    logic [2:0]            slot_index;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]            slot_number;
    logic                  hit;
    logic                  thrash_error;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
  } out_item_t;

  // update applied to the cells at commit
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_FILL,
    UPD_RELEASE,
    UPD_CLR_PERM,
    UPD_CLR_CACHE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic                  set_pin;
    logic                  set_perm;
    logic [LAYER_BITS-1:0] layer;
  } cell_cmd_t;

  // flags carried from cell to cell during a scan
  typedef struct packed {
    logic hit;
    logic found;
  } scan_flags_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

endpackage

FILE: hw/rtl/psc_cell.sv
// one slot of the replacer: slot state plus one stage of the scan chain
// each cycle the cell folds its slot into the carry from its left neighbor
// depends on psc_pkg
module psc_cell #(
  parameter int IDX_W      = 3,
  parameter int STAMP_BITS = psc_pkg::STAMP_BITS_DEF,
  parameter int KEY_W      = 32,
  parameter int MY_IDX     = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            policy,
  input  logic [psc_pkg::LAYER_BITS-1:0]  search_layer,
  input  psc_pkg::scan_flags_t            flags_in,
  input  logic [IDX_W-1:0]                hit_idx_in,
  input  logic [IDX_W-1:0]                best_idx_in,
  input  logic [KEY_W-1:0]                best_key_in,
  output psc_pkg::scan_flags_t            flags_out_r,
  output logic [IDX_W-1:0]                hit_idx_out_r,
  output logic [IDX_W-1:0]                best_idx_out_r,
  output logic [KEY_W-1:0]                best_key_out_r,
  input  logic                            sel,
  input  psc_pkg::cell_cmd_t              cmd,
  input  logic [STAMP_BITS-1:0]           new_stamp
);
  import psc_pkg::*;

  logic                  valid_r;
  logic [LAYER_BITS-1:0] layer_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [COUNT_BITS-1:0] uses_r;
  logic                  pin_r;
  logic                  perm_r;

  logic                  is_hit;
  logic                  cand;
  logic                  take;
  logic [KEY_W-1:0]      my_key;

  scan_flags_t           flags_nxt;
  logic [IDX_W-1:0]      hit_idx_nxt;
  logic [IDX_W-1:0]      best_idx_nxt;
  logic [KEY_W-1:0]      best_key_nxt;

  // scan stage: first hit and first lowest-key unpinned slot
  always_comb begin
    my_key       = policy ? KEY_W'(uses_r) : KEY_W'(stamp_r);
    is_hit       = !flags_in.hit && valid_r && (layer_r == search_layer);
    cand         = !pin_r && !perm_r;
    take         = cand && (!flags_in.found || (my_key < best_key_in));
    flags_nxt.hit   = flags_in.hit || is_hit;
    flags_nxt.found = flags_in.found || cand;
    hit_idx_nxt  = is_hit ? IDX_W'(MY_IDX) : hit_idx_in;
    best_idx_nxt = take ? IDX_W'(MY_IDX) : best_idx_in;
    best_key_nxt = take ? my_key : best_key_in;
  end

  // carry register toward the right neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_out_r <= '0;
    end else begin
      flags_out_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_out_r  <= hit_idx_nxt;
    best_idx_out_r <= best_idx_nxt;
    best_key_out_r <= best_key_nxt;
  end

  // slot state update from the commit command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      layer_r <= '0;
      stamp_r <= '0;
      uses_r  <= '0;
      pin_r   <= 1'b0;
      perm_r  <= 1'b0;
    end else begin
      unique case (cmd.op)
        UPD_HIT: begin
          if (sel) begin
            stamp_r <= new_stamp;
            if (uses_r != '1) uses_r <= uses_r + 1'b1;
            if (cmd.set_pin) pin_r <= 1'b1;
            if (cmd.set_perm) perm_r <= 1'b1;
          end
        end
        UPD_FILL: begin
          if (sel) begin
            valid_r <= 1'b1;
            layer_r <= cmd.layer;
            stamp_r <= new_stamp;
            uses_r  <= COUNT_BITS'(1);
            if (cmd.set_pin) pin_r <= 1'b1;
            if (cmd.set_perm) perm_r <= 1'b1;
          end
        end
        UPD_RELEASE: begin
          if (sel) pin_r <= 1'b0;
        end
        UPD_CLR_PERM: begin
          perm_r <= 1'b0;
        end
        UPD_CLR_CACHE: begin
          if (!pin_r && !perm_r) begin
            valid_r <= 1'b0;
            layer_r <= '0;
            stamp_r <= '0;
            uses_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pinned_slot_cache_replacer.sv
// top level of the pinned slot cache replacer: controller plus a chain of slot cells
// depends on psc_pkg and psc_cell
//
// usage:
//   input channel: drive in_data and raise start; the beat is taken at an edge where
//   start is high and busy is low. busy stays high until the result is produced.
//   result channel: out_valid pulses for one cycle with out_data; the receiver cannot
//   stall, so it must take the beat in that cycle.
//   config channel: cfg_data (replacement policy, 0 lru, 1 lfu) is written at an edge
//   where cfg_valid and cfg_ready are high; cfg_ready is high whenever busy is low.
// sequence:
//   an access (func 0 or 3) walks the slot chain one cell per cycle, then commits;
//   out_valid is registered from the commit state. other functions go straight to the
//   commit without a walk. a new beat can be taken at the edge that ends the result
//   cycle, so the block does not take a new beat until the last result is shown.
// reset:
//   synchronous active-low reset empties all slots, drops all pins, zeroes the use
//   clock and the hit and miss totals, and selects lru.
module pinned_slot_cache_replacer #(
  parameter int SLOTS      = psc_pkg::SLOTS_DEF,
  parameter int STAMP_BITS = psc_pkg::STAMP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  psc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output psc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import psc_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W = (STAMP_BITS > COUNT_BITS) ? STAMP_BITS : COUNT_BITS;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  ctrl_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]      cnt_r;
  in_item_t              item_r;
  logic                  policy_r;
  logic [STAMP_BITS-1:0] clock_r;
  logic [COUNT_BITS-1:0] hits_r, hits_nxt;
  logic [COUNT_BITS-1:0] misses_r, misses_nxt;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // chain links, link 0 is the empty carry
  scan_flags_t           flg  [SLOTS+1];
  logic [IDX_W-1:0]      hidx [SLOTS+1];
  logic [IDX_W-1:0]      bidx [SLOTS+1];
  logic [KEY_W-1:0]      bkey [SLOTS+1];

  cell_cmd_t             cmd;
  logic [SLOTS-1:0]      sel;
  logic [IDX_W-1:0]      tgt;
  logic                  res_hit;
  logic                  res_err;
  logic                  adv;
  logic                  hit_inc;
  logic                  miss_inc;
  logic [STAMP_BITS-1:0] new_stamp;
  logic                  accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign flg[0]  = '0;
  assign hidx[0] = '0;
  assign bidx[0] = '0;
  assign bkey[0] = '0;

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    psc_cell #(
      .IDX_W      (IDX_W),
      .STAMP_BITS (STAMP_BITS),
      .KEY_W      (KEY_W),
      .MY_IDX     (g)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .policy         (policy_r),
      .search_layer   (item_r.layer_num),
      .flags_in       (flg[g]),
      .hit_idx_in     (hidx[g]),
      .best_idx_in    (bidx[g]),
      .best_key_in    (bkey[g]),
      .flags_out_r    (flg[g+1]),
      .hit_idx_out_r  (hidx[g+1]),
      .best_idx_out_r (bidx[g+1]),
      .best_key_out_r (bkey[g+1]),
      .sel            (sel[g]),
      .cmd            (cmd),
      .new_stamp      (new_stamp)
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.func == FUNC_ACCESS || in_data.func == FUNC_ACCESS_PERM) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r == IDX_W'(SLOTS - 1)) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // commit decision from the end of the chain
  always_comb begin
    cmd       = '0;
    cmd.op    = UPD_NONE;
    cmd.layer = item_r.layer_num;
    sel       = '0;
    tgt       = '0;
    res_hit   = 1'b0;
    res_err   = 1'b0;
    adv       = 1'b0;
    hit_inc   = 1'b0;
    miss_inc  = 1'b0;
    if (state_r == ST_COMMIT) begin
      unique case (item_r.func)
        FUNC_ACCESS, FUNC_ACCESS_PERM: begin
          cmd.set_pin  = (item_r.func == FUNC_ACCESS);
          cmd.set_perm = (item_r.func == FUNC_ACCESS_PERM);
          priority if (flg[SLOTS].hit) begin
            cmd.op  = UPD_HIT;
            tgt     = hidx[SLOTS];
            res_hit = 1'b1;
            adv     = 1'b1;
            hit_inc = cmd.set_pin;
          end else if (flg[SLOTS].found) begin
            cmd.op   = UPD_FILL;
            tgt      = bidx[SLOTS];
            adv      = 1'b1;
            miss_inc = cmd.set_pin;
          end else begin
            res_err = 1'b1;
          end
          for (int i = 0; i < SLOTS; i++) sel[i] = (tgt == IDX_W'(i));
        end
        FUNC_RELEASE: begin
          cmd.op = UPD_RELEASE;
          for (int i = 0; i < SLOTS; i++) sel[i] = (7'(item_r.slot_index) == 7'(i));
        end
        FUNC_CLR_PERM:  cmd.op = UPD_CLR_PERM;
        FUNC_CLR_CACHE: cmd.op = UPD_CLR_CACHE;
        default: ;
      endcase
    end
  end

  // saturating clock and totals
  always_comb begin
    new_stamp  = (clock_r != STAMP_MAX) ? clock_r + 1'b1 : clock_r;
    hits_nxt   = (hit_inc && hits_r != '1) ? hits_r + 1'b1 : hits_r;
    misses_nxt = (miss_inc && misses_r != '1) ? misses_r + 1'b1 : misses_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      policy_r    <= 1'b0;
      clock_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= (state_r == ST_SCAN) ? cnt_r + 1'b1 : '0;
      out_valid_r <= (state_r == ST_COMMIT);
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      if (adv) clock_r <= new_stamp;
      if (cfg_valid && cfg_ready) policy_r <= cfg_data;
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (state_r == ST_COMMIT) begin
      out_data_r.slot_number  <= 3'(tgt);
      out_data_r.hit          <= res_hit;
      out_data_r.thrash_error <= res_err;
      out_data_r.hit_total    <= hits_nxt;
      out_data_r.miss_total   <= misses_nxt;
    end
  end

endmodule

FILE: hw/rtl/psc_checker.sv
// port-level checks for the pinned slot cache replacer, bound to the top level
// depends on psc_pkg
module psc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input psc_pkg::out_item_t out_data,
  input logic               cfg_ready
);
  import psc_pkg::*;

  // a taken beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("beat taken but block not busy");

  // one result per beat, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // result shows only once the block is idle again
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && cfg_ready)
    else $error("result shown while busy");

  // a thrash result names no slot and no hit
  a_thrash_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.thrash_error) |-> (out_data.slot_number == 3'd0 && !out_data.hit))
    else $error("thrash result carries slot or hit");

  // config is refused while a beat is in flight
  a_cfg_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready)
    else $error("config ready while busy");

endmodule

bind pinned_slot_cache_replacer psc_checker u_psc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

FILE: tb/tb_pinned_slot_cache_replacer.sv
// self-checking testbench for pinned_slot_cache_replacer: directed and random beats
// checked against an in-bench model of the slot table, pins, stamps and counters
// depends on psc_pkg and the replacer rtl
module tb_pinned_slot_cache_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int NSLOTS = SLOTS_DEF;
  // access walks the slot chain then commits, plus some margin
  localparam int DRAIN_CYCLES = NSLOTS + 6;
  // depth of the expected result ring
  localparam int EXP_DEPTH = 16;

  // codes the block treats as no-ops
  localparam logic [2:0] FUNC_UNUSED5 = 3'd5;
  localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  pinned_slot_cache_replacer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic                  tbl_valid [NSLOTS];
  logic [LAYER_BITS-1:0] tbl_layer [NSLOTS];
  logic [31:0]           tbl_stamp [NSLOTS];
  logic [COUNT_BITS-1:0] tbl_uses  [NSLOTS];
  logic                  tbl_pin   [NSLOTS];
  logic                  tbl_perm  [NSLOTS];
  logic [31:0]           use_clock = '0;
  logic [COUNT_BITS-1:0] hit_count = '0;
  logic [COUNT_BITS-1:0] miss_count = '0;
  logic                  policy = POLICY_LRU;

  // ring of expected results, written by the sender and read by the checker
  out_item_t expected_beats [EXP_DEPTH];
  int        exp_wr = 0;
  int        exp_rd = 0;
  int        sender_gap_pct = 0;
  int        error_count = 0;
  int        beats_sent = 0;
  int        beats_checked = 0;
  int        hits_seen = 0;
  int        thrash_seen = 0;
  int        policy_writes = 0;

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_layer[i] = '0;
      tbl_stamp[i] = '0;
      tbl_uses[i]  = '0;
      tbl_pin[i]   = 1'b0;
      tbl_perm[i]  = 1'b0;
    end
  end

  // advance the shadow table by one beat and return the result it should produce
  function automatic out_item_t cache_table_step(input in_item_t b);
    out_item_t r;
    int        slot;
    logic      is_hit;
    r = '0;
    case (b.func)
      FUNC_ACCESS, FUNC_ACCESS_PERM: begin
        slot = -1;
        is_hit = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!is_hit && tbl_valid[i] && tbl_layer[i] == b.layer_num) begin
            is_hit = 1'b1;
            slot = i;
          end
        end
        // victim search over slots with no pin, lowest index wins ties
        if (!is_hit) begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (!tbl_pin[i] && !tbl_perm[i]) begin
              if (slot < 0)
                slot = i;
              else if (policy == POLICY_LRU ? (tbl_stamp[i] < tbl_stamp[slot])
                                            : (tbl_uses[i] < tbl_uses[slot]))
                slot = i;
            end
          end
        end
        if (slot < 0) begin
          r.thrash_error = 1'b1;
        end else begin
          if (use_clock != '1) use_clock = use_clock + 1;
          tbl_stamp[slot] = use_clock;
          if (is_hit) begin
            if (tbl_uses[slot] != '1) tbl_uses[slot] = tbl_uses[slot] + 1;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_layer[slot] = b.layer_num;
            tbl_uses[slot]  = 1;
          end
          r.slot_number = slot[2:0];
          r.hit = is_hit;
          if (b.func == FUNC_ACCESS) begin
            tbl_pin[slot] = 1'b1;
            if (is_hit) begin
              if (hit_count != '1) hit_count = hit_count + 1;
            end else begin
              if (miss_count != '1) miss_count = miss_count + 1;
            end
          end else begin
            tbl_perm[slot] = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (b.slot_index < NSLOTS) tbl_pin[b.slot_index] = 1'b0;
      end
      FUNC_CLR_PERM: begin
        for (int i = 0; i < NSLOTS; i++) tbl_perm[i] = 1'b0;
      end
      FUNC_CLR_CACHE: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (!tbl_pin[i] && !tbl_perm[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_layer[i] = '0;
            tbl_stamp[i] = '0;
            tbl_uses[i]  = '0;
          end
        end
      end
      default: ;
    endcase
    r.hit_total  = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  // send one beat with an optional random gap, predict at the accepting edge
  task automatic send_beat(input logic [2:0] func, input logic [LAYER_BITS-1:0] layer,
                           input logic [2:0] sidx);
    in_item_t b;
    b.func = func;
    b.layer_num = layer;
    b.slot_index = sidx;
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      in_data <= '0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_beats[exp_wr[3:0]] = cache_table_step(b);
    exp_wr++;
    beats_sent++;
  endtask

  // stop sending and wait until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic p);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    policy = p;
    policy_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      beats_checked++;
      if (out_data.hit) hits_seen++;
      if (out_data.thrash_error) thrash_seen++;
      if (exp_wr == exp_rd) begin
        $display("%0t unexpected result beat: expected none actual %h", $realtime, out_data);
        error_count++;
      end else begin
        want = expected_beats[exp_rd[3:0]];
        exp_rd++;
        check_field("slot_number", 32'(want.slot_number), 32'(out_data.slot_number));
        check_field("hit", 32'(want.hit), 32'(out_data.hit));
        check_field("thrash_error", 32'(want.thrash_error), 32'(out_data.thrash_error));
        check_field("hit_total", want.hit_total, out_data.hit_total);
        check_field("miss_total", want.miss_total, out_data.miss_total);
      end
    end
  end

  // lru fills of every slot with edge layer ids, hit on a pinned slot, then all pinned
  task automatic test_lru_fill_and_thrash();
    send_beat(FUNC_ACCESS, 16'h0000, 3'd7);
    send_beat(FUNC_ACCESS, 16'hFFFF, 3'd0);
    for (int i = 1; i <= 6; i++) send_beat(FUNC_ACCESS, 16'(i), 3'd0);
    send_beat(FUNC_ACCESS, 16'hFFFF, 3'd0);
    send_beat(FUNC_ACCESS, 16'h1234, 3'd0);
  endtask

  // releases, permanent pin, cache clear, permanent pin clear and unused codes
  task automatic test_release_and_clears();
    send_beat(FUNC_RELEASE, 16'hFFFF, 3'd0);
    send_beat(FUNC_RELEASE, 16'h0000, 3'd7);
    send_beat(FUNC_RELEASE, 16'h0000, 3'd7);
    send_beat(FUNC_ACCESS_PERM, 16'hAAAA, 3'd0);
    send_beat(FUNC_CLR_CACHE, 16'h5555, 3'd5);
    send_beat(FUNC_CLR_PERM, 16'h0000, 3'd0);
    send_beat(FUNC_UNUSED5, 16'hFFFF, 3'd7);
    send_beat(FUNC_UNUSED6, 16'h0001, 3'd2);
    send_beat(FUNC_UNUSED7, 16'h8000, 3'd4);
  endtask

  // lfu picks the least used unpinned slot, not the oldest
  task automatic test_lfu_victim();
    send_beat(FUNC_RELEASE, 16'h0000, 3'd1);
    send_beat(FUNC_RELEASE, 16'h0000, 3'd2);
    send_beat(FUNC_ACCESS, 16'h5555, 3'd0);
    send_beat(FUNC_ACCESS_PERM, 16'h5555, 3'd0);
  endtask

  // accesses and releases with layers mostly from a small pool, releases so victims exist
  task automatic test_random_traffic(input int count, input int gap_pct);
    logic [2:0]            func;
    logic [LAYER_BITS-1:0] layer;
    int                    roll;
    sender_gap_pct = gap_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 42)      func = FUNC_ACCESS;
      else if (roll < 78) func = FUNC_RELEASE;
      else if (roll < 85) func = FUNC_ACCESS_PERM;
      else if (roll < 91) func = FUNC_CLR_PERM;
      else if (roll < 96) func = FUNC_CLR_CACHE;
      else                func = 3'($urandom_range(7, 5));
      if ($urandom_range(99) < 75) layer = 16'($urandom_range(11));
      else                          layer = 16'($urandom_range(65535));
      send_beat(func, layer, 3'($urandom_range(7)));
      // hold off once mid-phase until the block has caught up
      if (n == count / 2) drain_results();
    end
    sender_gap_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_lru_fill_and_thrash();
    test_release_and_clears();
    write_policy(POLICY_LFU);
    test_lfu_victim();
    test_random_traffic(150, 10);
    write_policy(POLICY_LRU);
    test_random_traffic(150, 65);
    write_policy(POLICY_LFU);
    test_random_traffic(150, 0);

    drain_results();
    $display("run: %0d beats sent, %0d results checked, %0d hits, %0d thrash errors",
             beats_sent, beats_checked, hits_seen, thrash_seen);
    $display("run: %0d policy writes over lru and lfu, %0d errors", policy_writes,
             error_count);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d results outstanding", exp_wr - exp_rd);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/psc_pkg.sv
hw/rtl/psc_cell.sv
hw/rtl/pinned_slot_cache_replacer.sv
hw/rtl/psc_checker.sv
tb/tb_pinned_slot_cache_replacer.sv
